@@ rtl/core/atz_pkg.sv @@
// ----------------------------------------------------------------------------
// atz_pkg: shared types and codes of the trigger zone table
// Op and result codes, entry word layout, box type and sequencer states.
// ----------------------------------------------------------------------------
package atz_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int COORD_W         = 16;
  localparam int TAG_W           = 16;
  localparam int FLAG_W          = 3;
  localparam int SLOT_W          = 6;
  localparam int KIND_W          = 3;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_FIRE  = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRIG    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEARED = 3'd4;

  // Flag bit positions
  localparam int FLAG_ONCE   = 0;
  localparam int FLAG_ACTION = 1;
  localparam int FLAG_FIRED  = 2;

  // Box: center x, y (signed) and full width, height (unsigned)
  typedef struct packed {
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } box_t;

  // One table entry as held in the entry memory
  typedef struct packed {
    box_t              box;
    logic [TAG_W-1:0]  tag;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_TEST_A,
    S_TEST_B,
    S_FINISH
  } state_t;

endpackage

@@ rtl/core/atz_ram.sv @@
// ----------------------------------------------------------------------------
// atz_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module atz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/atz_overlap.sv @@
// ----------------------------------------------------------------------------
// atz_overlap: inclusive box overlap test
// Compares two center-plus-size boxes on doubled coordinates.
// ----------------------------------------------------------------------------
module atz_overlap (
  input  atz_pkg::box_t ebox,
  input  atz_pkg::box_t qbox,
  output logic          hit
);

  logic signed [17:0] a0, a1, b0, b1, c0, c1, d0, d1;

  // span = 2*center -/+ size, 18 bits signed holds every case
  always_comb begin
    a0 = $signed({ebox.x[15], ebox.x, 1'b0}) - $signed({2'b00, ebox.w});
    a1 = $signed({ebox.x[15], ebox.x, 1'b0}) + $signed({2'b00, ebox.w});
    c0 = $signed({ebox.y[15], ebox.y, 1'b0}) - $signed({2'b00, ebox.h});
    c1 = $signed({ebox.y[15], ebox.y, 1'b0}) + $signed({2'b00, ebox.h});
    b0 = $signed({qbox.x[15], qbox.x, 1'b0}) - $signed({2'b00, qbox.w});
    b1 = $signed({qbox.x[15], qbox.x, 1'b0}) + $signed({2'b00, qbox.w});
    d0 = $signed({qbox.y[15], qbox.y, 1'b0}) - $signed({2'b00, qbox.h});
    d1 = $signed({qbox.y[15], qbox.y, 1'b0}) + $signed({2'b00, qbox.h});
    hit = !((a1 < b0) || (b1 < a0) || (c1 < d0) || (d1 < c0));
  end

endmodule

@@ rtl/core/aabb_trigger_zone_table.sv @@
// ----------------------------------------------------------------------------
// aabb_trigger_zone_table: table of trigger boxes with overlap query
// Stores up to MAX_ENTRIES boxes and tests query boxes or tags against them.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op and the payload ports and raise start; the beat
//   is taken at a clock edge where start is high and busy is low.
//   Result channel: each result beat sits on kind/slot/hit_tag/last for one
//   cycle with strobe high. The receiver cannot stall; every beat must be
//   taken when shown. last marks the final beat of a command.
//   Clear and add finish at once: their single beat shows in the cycle after
//   the command, and busy stays low, so commands of these kinds can follow
//   back to back.
//   Query and fire walk the live entries through one shared overlap unit and
//   one entry memory read port: a read-setup state, then for each entry a test
//   of box A and a test of box B or the tag check, then a closing state. busy
//   stays high through the walk (a fire stops at its first tag match; on an
//   empty table only the closing state remains, so busy is high for one cycle).
//   Triggered beats trail the entry that caused them by one hit, since the
//   last flag of a beat is only known once the next hit or the end is seen.
//   Reset empties the table and idles the sequencer; the entry memory holds
//   no reset and its read data is only used below the live count.
// ----------------------------------------------------------------------------
module aabb_trigger_zone_table #(
  parameter int MAX_ENTRIES = atz_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic signed [15:0]          ax,
  input  logic signed [15:0]          ay,
  input  logic [15:0]                 aw,
  input  logic [15:0]                 ah,
  input  logic signed [15:0]          bx,
  input  logic signed [15:0]          by,
  input  logic [15:0]                 bw,
  input  logic [15:0]                 bh,
  input  logic                        one_shot,
  input  logic [15:0]                 tag,
  input  logic                        has_action,
  output logic                        strobe,
  output logic [atz_pkg::KIND_W-1:0]  kind,
  output logic [atz_pkg::SLOT_W-1:0]  slot,
  output logic [15:0]                 hit_tag,
  output logic                        last
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  atz_pkg::state_t state, state_next;

  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic [1:0]         op_q;
  atz_pkg::box_t      qa, qb;
  logic [15:0]        want_tag;
  logic               hit_a;
  logic               pend_valid;
  logic [AW-1:0]      pend_slot;
  logic [15:0]        pend_tag;

  // Entry memory ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  atz_pkg::entry_t             ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [atz_pkg::ENTRY_W-1:0] ram_rdata;
  atz_pkg::entry_t             entry;

  // Shared compare unit
  atz_pkg::box_t cmp_box;
  logic          hit;

  // Walk control
  logic accept;
  logic spent;
  logic tag_eq;
  logic match;
  logic act;
  logic at_end;
  logic stop;
  logic full;

  // Result beat staged for the output register
  logic                       emit;
  logic [atz_pkg::KIND_W-1:0] emit_kind;
  logic [atz_pkg::SLOT_W-1:0] emit_slot;
  logic [15:0]                emit_tag;
  logic                       emit_last;

  assign busy   = (state != atz_pkg::S_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(MAX_ENTRIES));

  atz_ram #(
    .WIDTH (atz_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign entry = atz_pkg::entry_t'(ram_rdata);

  // Box A in the first test cycle of an entry, box B in the second
  assign cmp_box = (state == atz_pkg::S_TEST_B) ? qb : qa;

  atz_overlap u_overlap (
    .ebox (entry.box),
    .qbox (cmp_box),
    .hit  (hit)
  );

  assign spent  = entry.flags[atz_pkg::FLAG_ONCE] && entry.flags[atz_pkg::FLAG_FIRED];
  assign tag_eq = (entry.tag == want_tag);
  assign match  = (op_q == atz_pkg::OP_QUERY) ? (hit_a || hit) : tag_eq;
  assign act    = (state == atz_pkg::S_TEST_B) && !spent && match;
  assign at_end = ((CW'(idx) + CW'(1)) == count);
  // A fire stops on the first tag match, spent or not
  assign stop   = at_end || ((op_q == atz_pkg::OP_FIRE) && tag_eq);

  // Read the current entry; prefetch the next one during the second test
  assign ram_raddr = (state == atz_pkg::S_TEST_B) ? (idx + AW'(1)) : idx;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      atz_pkg::S_IDLE: begin
        if (accept && (op inside {atz_pkg::OP_QUERY, atz_pkg::OP_FIRE})) begin
          state_next = (count == '0) ? atz_pkg::S_FINISH : atz_pkg::S_READ;
        end
      end
      atz_pkg::S_READ:   state_next = atz_pkg::S_TEST_A;
      atz_pkg::S_TEST_A: state_next = atz_pkg::S_TEST_B;
      atz_pkg::S_TEST_B: state_next = stop ? atz_pkg::S_FINISH : atz_pkg::S_TEST_A;
      atz_pkg::S_FINISH: state_next = atz_pkg::S_IDLE;
      default:           state_next = atz_pkg::S_IDLE;
    endcase
  end

  // Memory writes and result beats
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = entry;
    emit      = 1'b0;
    emit_kind = atz_pkg::KIND_NONE;
    emit_slot = '0;
    emit_tag  = '0;
    emit_last = 1'b0;
    case (state)
      atz_pkg::S_IDLE: begin
        ram_waddr       = count[AW-1:0];
        ram_wdata.box   = '{h: ah, w: aw, y: ay, x: ax};
        ram_wdata.tag   = tag;
        ram_wdata.flags = '0;
        ram_wdata.flags[atz_pkg::FLAG_ONCE]   = one_shot;
        ram_wdata.flags[atz_pkg::FLAG_ACTION] = has_action;
        if (accept) begin
          case (op)
            atz_pkg::OP_CLEAR: begin
              emit      = 1'b1;
              emit_kind = atz_pkg::KIND_CLEARED;
              emit_last = 1'b1;
            end
            atz_pkg::OP_ADD: begin
              emit      = 1'b1;
              emit_last = 1'b1;
              if (full) begin
                emit_kind = atz_pkg::KIND_FULL;
              end else begin
                ram_we    = 1'b1;
                emit_kind = atz_pkg::KIND_ADDED;
                emit_slot = atz_pkg::SLOT_W'(count);
              end
            end
            default: ;
          endcase
        end
      end
      atz_pkg::S_TEST_B: begin
        // Mark a one-shot entry spent once it has been hit or matched by tag
        ram_wdata.flags[atz_pkg::FLAG_FIRED] = 1'b1;
        ram_we = act && entry.flags[atz_pkg::FLAG_ONCE];
        // A new reporting hit releases the held one as a non-final beat
        if (act && entry.flags[atz_pkg::FLAG_ACTION] && pend_valid) begin
          emit      = 1'b1;
          emit_kind = atz_pkg::KIND_TRIG;
          emit_slot = atz_pkg::SLOT_W'(pend_slot);
          emit_tag  = pend_tag;
        end
      end
      atz_pkg::S_FINISH: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        if (pend_valid) begin
          emit_kind = atz_pkg::KIND_TRIG;
          emit_slot = atz_pkg::SLOT_W'(pend_slot);
          emit_tag  = pend_tag;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= atz_pkg::S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      case (state)
        atz_pkg::S_IDLE: begin
          if (accept) begin
            pend_valid <= 1'b0;
            if (op == atz_pkg::OP_CLEAR) begin
              count <= '0;
            end else if (op == atz_pkg::OP_ADD && !full) begin
              count <= count + CW'(1);
            end
          end
        end
        atz_pkg::S_TEST_B: begin
          if (act && entry.flags[atz_pkg::FLAG_ACTION]) begin
            pend_valid <= 1'b1;
          end
        end
        atz_pkg::S_FINISH: pend_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind    <= emit_kind;
    slot    <= emit_slot;
    hit_tag <= emit_tag;
    last    <= emit_last;
    case (state)
      atz_pkg::S_IDLE: begin
        if (accept) begin
          op_q     <= op;
          qa       <= '{h: ah, w: aw, y: ay, x: ax};
          qb       <= '{h: bh, w: bw, y: by, x: bx};
          want_tag <= tag;
          idx      <= '0;
        end
      end
      atz_pkg::S_TEST_A: hit_a <= hit;
      atz_pkg::S_TEST_B: begin
        if (act && entry.flags[atz_pkg::FLAG_ACTION]) begin
          pend_slot <= idx;
          pend_tag  <= entry.tag;
        end
        if (!stop) begin
          idx <= idx + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_walk_live: assert property (@(posedge clk) disable iff (rst)
    (state == atz_pkg::S_TEST_A || state == atz_pkg::S_TEST_B) |-> (CW'(idx) < count))
    else $error("walk reached a slot past the live entries");

  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (strobe && last))
    else $error("walk ended without a final result beat");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy)
    else $error("held result left behind after the walk");

endmodule
